// ----- src/lts_pkg.sv -----
// Package for the listen trigger sequencer: transaction payload types,
// event, cause and icon codes, register map and register reset values.
// No dependencies.
package lts_pkg;

  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_TOGGLE    = 2'd1;
  localparam logic [1:0] KIND_PROCESSED = 2'd2;
  localparam logic [1:0] KIND_LINK_FAIL = 2'd3;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_BEAT     = 2'd1;
  localparam logic [1:0] CAUSE_FALLBACK = 2'd2;

  localparam logic [1:0] ICON_NONE     = 2'd0;
  localparam logic [1:0] ICON_ENABLED  = 2'd1;
  localparam logic [1:0] ICON_DISABLED = 2'd2;

  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [2:0] REG_TOGGLE_DISPLAY = 3'd0;
  localparam logic [2:0] REG_MUSIC_STABLE   = 3'd1;
  localparam logic [2:0] REG_FALLBACK       = 3'd2;
  localparam logic [2:0] REG_RECENT_ONSET   = 3'd3;
  localparam logic [2:0] REG_MIN_BEAT_CONF  = 3'd4;
  localparam logic [2:0] REG_FAIL_COOLDOWN  = 3'd5;
  localparam logic [2:0] REG_OK_COOLDOWN    = 3'd6;
  localparam logic [2:0] REG_RECORD_DUR     = 3'd7;

  localparam logic [15:0] RST_TOGGLE_DISPLAY = 16'd780;
  localparam logic [15:0] RST_MUSIC_STABLE   = 16'd1500;
  localparam logic [15:0] RST_FALLBACK       = 16'd1200;
  localparam logic [15:0] RST_RECENT_ONSET   = 16'd180;
  localparam logic [7:0]  RST_MIN_BEAT_CONF  = 8'd18;
  localparam logic [31:0] RST_FAIL_COOLDOWN  = 32'd60000;
  localparam logic [31:0] RST_OK_COOLDOWN    = 32'd420000;
  localparam logic [15:0] RST_RECORD_DUR     = 16'd12000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic        playback_active;
    logic        mic_busy;
    logic        music_present;
    logic [15:0] beat_bpm;
    logic [7:0]  beat_confidence;
    logic [31:0] last_onset_ms;
    logic        record_start_ok;
    logic        processed_ok;
  } lts_in_t;

  typedef struct packed {
    logic       mode_enabled;
    logic       start_recording;
    logic [1:0] trigger_cause;
    logic       cancel_work;
    logic       cancel_microphone;
    logic       owns_recording;
    logic [1:0] icon_shown;
    logic       cooldown_active;
  } lts_out_t;

endpackage

// ----- src/listen_trigger_sequencer.sv -----
// Listen trigger sequencer: event register, single-pass mode logic and
// result register, plus the APB-style register file.
// Depends on lts_pkg.
// An input transaction passes the event register, then the result register;
// throughput: one transaction per cycle while out_ready does not stall the
// result register; the mode logic between the two registers evaluates one event in one pass.
// Synchronous active-low reset clears both valid flags, all mode state
// (deadlines and window marks to unset, icon none) and loads the register
// defaults; no warm-up sweep follows.
module listen_trigger_sequencer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lts_pkg::lts_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lts_pkg::lts_out_t                    out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [lts_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [lts_pkg::CFG_DATA_BITS-1:0]    cfg_pwdata,
  output logic [lts_pkg::CFG_DATA_BITS-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);
  import lts_pkg::*;

  typedef logic [TIME_BITS-1:0] tm_t;

  function automatic tm_t tsub(input tm_t a, input tm_t b);
    tsub = a - b;
  endfunction

  function automatic logic not_reached(input tm_t now, input tm_t dl);
    tm_t d;
    d = tsub(now, dl);
    not_reached = d[TIME_BITS-1];
  endfunction

  // register file
  logic [15:0] toggle_display_r, music_stable_r, fallback_r, recent_onset_r;
  logic [7:0]  min_conf_r;
  logic [31:0] fail_cool_r, ok_cool_r;
  logic [15:0] record_dur_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_display_r <= RST_TOGGLE_DISPLAY;
      music_stable_r   <= RST_MUSIC_STABLE;
      fallback_r       <= RST_FALLBACK;
      recent_onset_r   <= RST_RECENT_ONSET;
      min_conf_r       <= RST_MIN_BEAT_CONF;
      fail_cool_r      <= RST_FAIL_COOLDOWN;
      ok_cool_r        <= RST_OK_COOLDOWN;
      record_dur_r     <= RST_RECORD_DUR;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TOGGLE_DISPLAY: toggle_display_r <= cfg_pwdata[15:0];
        REG_MUSIC_STABLE:   music_stable_r   <= cfg_pwdata[15:0];
        REG_FALLBACK:       fallback_r       <= cfg_pwdata[15:0];
        REG_RECENT_ONSET:   recent_onset_r   <= cfg_pwdata[15:0];
        REG_MIN_BEAT_CONF:  min_conf_r       <= cfg_pwdata[7:0];
        REG_FAIL_COOLDOWN:  fail_cool_r      <= cfg_pwdata;
        REG_OK_COOLDOWN:    ok_cool_r        <= cfg_pwdata;
        REG_RECORD_DUR:     record_dur_r     <= cfg_pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_TOGGLE_DISPLAY: cfg_prdata = {16'd0, toggle_display_r};
      REG_MUSIC_STABLE:   cfg_prdata = {16'd0, music_stable_r};
      REG_FALLBACK:       cfg_prdata = {16'd0, fallback_r};
      REG_RECENT_ONSET:   cfg_prdata = {16'd0, recent_onset_r};
      REG_MIN_BEAT_CONF:  cfg_prdata = {24'd0, min_conf_r};
      REG_FAIL_COOLDOWN:  cfg_prdata = fail_cool_r;
      REG_OK_COOLDOWN:    cfg_prdata = ok_cool_r;
      REG_RECORD_DUR:     cfg_prdata = {16'd0, record_dur_r};
    endcase
  end

  // event register and result register
  lts_in_t  ev_r;
  logic     ev_valid_r;
  lts_out_t res_r, res_nxt;
  logic     res_valid_r;
  logic     adv, in_acc;

  assign adv      = ev_valid_r & (~res_valid_r | out_ready);
  assign in_ready = ~ev_valid_r | adv;
  assign in_acc   = in_valid & in_ready;
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // mode state
  logic       en_r, en_nxt, own_r, own_nxt;
  tm_t        ready_dl_r, ready_dl_nxt, cool_dl_r, cool_dl_nxt;
  tm_t        music_since_r, music_since_nxt, armed_since_r, armed_since_nxt;
  logic [1:0] icon_kind_r, icon_kind_nxt;
  tm_t        icon_dl_r, icon_dl_nxt;

  tm_t  now_t, onset_t, arm_eff, cool_dur;
  logic beat_ok, recent, fb_due, fire, icon_on;

  assign now_t    = TIME_BITS'(ev_r.now_ms);
  assign onset_t  = TIME_BITS'(ev_r.last_onset_ms);
  assign arm_eff  = (armed_since_r == '0) ? now_t : armed_since_r;
  assign beat_ok  = (ev_r.beat_bpm != 16'd0) && (ev_r.beat_confidence >= min_conf_r);
  assign recent   = (onset_t != '0) && (now_t >= onset_t) &&
                    ((now_t - onset_t) <= TIME_BITS'(recent_onset_r));
  assign fb_due   = tsub(now_t, arm_eff) >= TIME_BITS'(fallback_r);
  assign fire     = fb_due | (beat_ok & recent);
  assign cool_dur = (ev_r.kind == KIND_PROCESSED && ev_r.processed_ok) ?
                    TIME_BITS'(ok_cool_r) : TIME_BITS'(fail_cool_r);

  always_comb begin
    en_nxt          = en_r;
    own_nxt         = own_r;
    ready_dl_nxt    = ready_dl_r;
    cool_dl_nxt     = cool_dl_r;
    music_since_nxt = music_since_r;
    armed_since_nxt = armed_since_r;
    icon_kind_nxt   = icon_kind_r;
    icon_dl_nxt     = icon_dl_r;
    res_nxt         = '0;
    res_nxt.trigger_cause = CAUSE_NONE;

    unique case (ev_r.kind)
      KIND_TICK: begin
        if (en_r && !ev_r.playback_active && !own_r && !ev_r.mic_busy &&
            !(cool_dl_r != '0 && not_reached(now_t, cool_dl_r))) begin
          cool_dl_nxt = '0;
          if (!(ready_dl_r != '0 && not_reached(now_t, ready_dl_r))) begin
            ready_dl_nxt = '0;
            if (!ev_r.music_present) begin
              music_since_nxt = '0;
              armed_since_nxt = '0;
            end else if (music_since_r == '0) begin
              music_since_nxt = now_t;
            end else if (tsub(now_t, music_since_r) >= TIME_BITS'(music_stable_r)) begin
              armed_since_nxt = arm_eff;
              if (fire) begin
                res_nxt.trigger_cause = fb_due ? CAUSE_FALLBACK : CAUSE_BEAT;
                music_since_nxt = '0;
                armed_since_nxt = '0;
                if (!ev_r.record_start_ok) begin
                  cool_dl_nxt  = now_t + cool_dur;
                end else begin
                  own_nxt = 1'b1;
                  res_nxt.start_recording = 1'b1;
                end
              end
            end
          end
        end
      end
      KIND_TOGGLE: begin
        en_nxt          = ~en_r;
        cool_dl_nxt     = '0;
        music_since_nxt = '0;
        armed_since_nxt = '0;
        icon_dl_nxt     = now_t + TIME_BITS'(toggle_display_r);
        if (!en_r) begin
          icon_kind_nxt = ICON_ENABLED;
          ready_dl_nxt  = now_t + TIME_BITS'(toggle_display_r);
        end else begin
          icon_kind_nxt = ICON_DISABLED;
          ready_dl_nxt  = '0;
          own_nxt       = 1'b0;
          res_nxt.cancel_work       = 1'b1;
          res_nxt.cancel_microphone = 1'b1;
        end
      end
      KIND_PROCESSED: begin
        if (own_r) begin
          own_nxt         = 1'b0;
          cool_dl_nxt     = now_t + cool_dur;
          ready_dl_nxt    = '0;
          music_since_nxt = '0;
          armed_since_nxt = '0;
        end
      end
      KIND_LINK_FAIL: begin
        if (en_r) begin
          en_nxt          = 1'b0;
          own_nxt         = 1'b0;
          ready_dl_nxt    = '0;
          cool_dl_nxt     = '0;
          music_since_nxt = '0;
          armed_since_nxt = '0;
          res_nxt.cancel_work = 1'b1;
        end
      end
    endcase

    // drop the icon once its deadline passes
    icon_on = (icon_kind_nxt != ICON_NONE) && not_reached(now_t, icon_dl_nxt);
    if (!icon_on) begin
      icon_kind_nxt = ICON_NONE;
      icon_dl_nxt   = '0;
    end

    res_nxt.mode_enabled    = en_nxt;
    res_nxt.owns_recording  = own_nxt;
    res_nxt.icon_shown      = icon_kind_nxt;
    res_nxt.cooldown_active = (cool_dl_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r    <= 1'b0;
      res_valid_r   <= 1'b0;
      en_r          <= 1'b0;
      own_r         <= 1'b0;
      ready_dl_r    <= '0;
      cool_dl_r     <= '0;
      music_since_r <= '0;
      armed_since_r <= '0;
      icon_kind_r   <= ICON_NONE;
      icon_dl_r     <= '0;
    end else begin
      if (in_acc) begin
        ev_valid_r <= 1'b1;
      end else if (adv) begin
        ev_valid_r <= 1'b0;
      end
      if (adv) begin
        res_valid_r   <= 1'b1;
        en_r          <= en_nxt;
        own_r         <= own_nxt;
        ready_dl_r    <= ready_dl_nxt;
        cool_dl_r     <= cool_dl_nxt;
        music_since_r <= music_since_nxt;
        armed_since_r <= armed_since_nxt;
        icon_kind_r   <= icon_kind_nxt;
        icon_dl_r     <= icon_dl_nxt;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r <= in_data;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  a_start_owns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_recording |->
      out_data.owns_recording && !out_data.cooldown_active &&
      out_data.trigger_cause != CAUSE_NONE)
    else $error("start without ownership or cause");

  a_cancel_mic_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cancel_microphone |->
      !out_data.mode_enabled && out_data.cancel_work && !out_data.owns_recording)
    else $error("microphone cancel while enabled");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode_enabled == en_r && out_data.owns_recording == own_r)
    else $error("result out of step with mode state");

  a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid)
    else $error("advanced transaction lost");

endmodule

// ----- tb/sv/lts_checker.sv -----
`timescale 1ns / 1ps
// Checker for the listen trigger sequencer: watches the event, result and register
// ports, predicts every result and compares it field by field with the block's output.
// Depends on lts_pkg.
module lts_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  lts_pkg::lts_in_t                  in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  lts_pkg::lts_out_t                 out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lts_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [lts_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  input  logic [lts_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  input  logic                              cfg_pready,
  output int                                mismatches,
  output int                                outstanding,
  output int                                checked,
  output int                                recordings_started
);
  import lts_pkg::*;

  logic [31:0] regs [0:7];
  logic        mode_on;
  logic        own_rec;
  logic [31:0] ready_at;
  logic [31:0] cooldown_at;
  logic [31:0] music_from;
  logic [31:0] armed_at;
  logic [1:0]  icon_code;
  logic [31:0] icon_until;
  lts_out_t    pending_results [$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s at result %0d: got %0h, want %0h", field, checked, got, want);
    mismatches++;
  endtask

  function automatic logic deadline_pending(input logic [31:0] now, input logic [31:0] at);
    logic [31:0] lag;
    lag = now - at;
    return lag[31];
  endfunction

  function automatic lts_out_t step_sequencer(input lts_in_t ev);
    lts_out_t    r;
    logic [31:0] now;
    logic        go;
    logic        beat_ready;
    logic        recent;
    logic        fallback;
    r = '0;
    now = ev.now_ms;
    case (ev.kind)
      KIND_TICK: begin
        go = mode_on && !ev.playback_active && !own_rec && !ev.mic_busy;
        if (go && cooldown_at != 32'd0) begin
          if (deadline_pending(now, cooldown_at)) go = 1'b0;
          else cooldown_at = 32'd0;
        end
        if (go && ready_at != 32'd0) begin
          if (deadline_pending(now, ready_at)) go = 1'b0;
          else ready_at = 32'd0;
        end
        if (go && !ev.music_present) begin
          music_from = 32'd0;
          armed_at = 32'd0;
          go = 1'b0;
        end
        if (go && music_from == 32'd0) begin
          music_from = now;
          go = 1'b0;
        end
        if (go && (now - music_from) < regs[REG_MUSIC_STABLE]) go = 1'b0;
        if (go) begin
          if (armed_at == 32'd0) armed_at = now;
          beat_ready = ev.beat_bpm != 16'd0 &&
                       {24'd0, ev.beat_confidence} >= regs[REG_MIN_BEAT_CONF];
          recent = ev.last_onset_ms != 32'd0 && now >= ev.last_onset_ms &&
                   (now - ev.last_onset_ms) <= regs[REG_RECENT_ONSET];
          fallback = (now - armed_at) >= regs[REG_FALLBACK];
          if (fallback || (beat_ready && recent)) begin
            r.trigger_cause = fallback ? CAUSE_FALLBACK : CAUSE_BEAT;
            if (!ev.record_start_ok) begin
              cooldown_at = now + regs[REG_FAIL_COOLDOWN];
              ready_at = 32'd0;
            end else begin
              own_rec = 1'b1;
              r.start_recording = 1'b1;
            end
            music_from = 32'd0;
            armed_at = 32'd0;
          end
        end
      end
      KIND_TOGGLE: begin
        mode_on = !mode_on;
        ready_at = 32'd0;
        cooldown_at = 32'd0;
        music_from = 32'd0;
        armed_at = 32'd0;
        icon_until = now + regs[REG_TOGGLE_DISPLAY];
        if (mode_on) begin
          icon_code = ICON_ENABLED;
          ready_at = icon_until;
        end else begin
          icon_code = ICON_DISABLED;
          own_rec = 1'b0;
          r.cancel_work = 1'b1;
          r.cancel_microphone = 1'b1;
        end
      end
      KIND_PROCESSED: begin
        if (own_rec) begin
          own_rec = 1'b0;
          cooldown_at = now + (ev.processed_ok ? regs[REG_OK_COOLDOWN] : regs[REG_FAIL_COOLDOWN]);
          ready_at = 32'd0;
          music_from = 32'd0;
          armed_at = 32'd0;
        end
      end
      default: begin
        if (mode_on) begin
          mode_on = 1'b0;
          own_rec = 1'b0;
          r.cancel_work = 1'b1;
          ready_at = 32'd0;
          cooldown_at = 32'd0;
          music_from = 32'd0;
          armed_at = 32'd0;
        end
      end
    endcase
    if (!(icon_code != ICON_NONE && deadline_pending(now, icon_until))) begin
      icon_code = ICON_NONE;
      icon_until = 32'd0;
    end
    r.mode_enabled = mode_on;
    r.owns_recording = own_rec;
    r.icon_shown = icon_code;
    r.cooldown_active = cooldown_at != 32'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    lts_out_t   want;
    logic [2:0] idx;
    if (!rst_n) begin
      regs[REG_TOGGLE_DISPLAY] = {16'd0, RST_TOGGLE_DISPLAY};
      regs[REG_MUSIC_STABLE]   = {16'd0, RST_MUSIC_STABLE};
      regs[REG_FALLBACK]       = {16'd0, RST_FALLBACK};
      regs[REG_RECENT_ONSET]   = {16'd0, RST_RECENT_ONSET};
      regs[REG_MIN_BEAT_CONF]  = {24'd0, RST_MIN_BEAT_CONF};
      regs[REG_FAIL_COOLDOWN]  = RST_FAIL_COOLDOWN;
      regs[REG_OK_COOLDOWN]    = RST_OK_COOLDOWN;
      regs[REG_RECORD_DUR]     = {16'd0, RST_RECORD_DUR};
      mode_on = 1'b0;
      own_rec = 1'b0;
      ready_at = 32'd0;
      cooldown_at = 32'd0;
      music_from = 32'd0;
      armed_at = 32'd0;
      icon_code = ICON_NONE;
      icon_until = 32'd0;
      pending_results.delete();
      mismatches = 0;
      checked = 0;
      recordings_started = 0;
      outstanding <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        idx = cfg_paddr[4:2];
        if (cfg_pwrite) begin
          case (idx)
            REG_MIN_BEAT_CONF: regs[idx] = {24'd0, cfg_pwdata[7:0]};
            REG_FAIL_COOLDOWN, REG_OK_COOLDOWN: regs[idx] = cfg_pwdata;
            default: regs[idx] = {16'd0, cfg_pwdata[15:0]};
          endcase
        end else if (cfg_prdata !== regs[idx]) begin
          report_mismatch("register readback", cfg_prdata, regs[idx]);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.mode_enabled !== want.mode_enabled)
            report_mismatch("mode_enabled", 32'(out_data.mode_enabled), 32'(want.mode_enabled));
          if (out_data.start_recording !== want.start_recording)
            report_mismatch("start_recording", 32'(out_data.start_recording),
                            32'(want.start_recording));
          if (out_data.trigger_cause !== want.trigger_cause)
            report_mismatch("trigger_cause", 32'(out_data.trigger_cause),
                            32'(want.trigger_cause));
          if (out_data.cancel_work !== want.cancel_work)
            report_mismatch("cancel_work", 32'(out_data.cancel_work), 32'(want.cancel_work));
          if (out_data.cancel_microphone !== want.cancel_microphone)
            report_mismatch("cancel_microphone", 32'(out_data.cancel_microphone),
                            32'(want.cancel_microphone));
          if (out_data.owns_recording !== want.owns_recording)
            report_mismatch("owns_recording", 32'(out_data.owns_recording),
                            32'(want.owns_recording));
          if (out_data.icon_shown !== want.icon_shown)
            report_mismatch("icon_shown", 32'(out_data.icon_shown), 32'(want.icon_shown));
          if (out_data.cooldown_active !== want.cooldown_active)
            report_mismatch("cooldown_active", 32'(out_data.cooldown_active),
                            32'(want.cooldown_active));
          if (want.start_recording) recordings_started++;
          checked++;
        end
      end
      if (in_valid && in_ready) pending_results.push_back(step_sequencer(in_data));
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- tb/sv/listen_trigger_sequencer_tb.sv -----
`timescale 1ns / 1ps
// Top of the listen trigger sequencer testbench: clock, reset, event and register
// stimulus, random idling on both channels, watchdog and verdict. Needs lts_pkg,
// listen_trigger_sequencer and lts_checker.
module listen_trigger_sequencer_tb;
  import lts_pkg::*;

  localparam int STALL_LIMIT = 2000;

  localparam logic [4:0] FL_PLAY  = 5'b10000;
  localparam logic [4:0] FL_MIC   = 5'b01000;
  localparam logic [4:0] FL_MUSIC = 5'b00100;
  localparam logic [4:0] FL_START = 5'b00010;
  localparam logic [4:0] FL_PROC  = 5'b00001;
  localparam logic [4:0] FL_GO    = FL_MUSIC | FL_START;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  lts_in_t                  in_data;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  lts_out_t                 out_data;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  int          mismatches;
  int          outstanding;
  int          checked;
  int          recordings_started;
  int          items_sent;
  int          settings_used;
  logic        steady;
  logic [31:0] now_cursor;
  logic [31:0] cur_fail_cd;
  logic [31:0] cur_ok_cd;
  int          cur_onset;
  int          cur_conf;
  int          time_span;

  listen_trigger_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lts_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .checked            (checked),
    .recordings_started (recordings_started)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 36);
  end

  function automatic lts_in_t compose_event(input logic [1:0] kind, input logic [31:0] now,
                                            input logic [15:0] bpm, input logic [7:0] conf,
                                            input logic [31:0] onset, input logic [4:0] flags);
    lts_in_t e;
    e.kind = kind;
    e.now_ms = now;
    e.beat_bpm = bpm;
    e.beat_confidence = conf;
    e.last_onset_ms = onset;
    {e.playback_active, e.mic_busy, e.music_present, e.record_start_ok, e.processed_ok} = flags;
    return e;
  endfunction

  function automatic lts_in_t shaped_event(input logic [1:0] kind);
    logic [15:0] bpm;
    logic [7:0]  conf;
    logic [31:0] onset;
    logic [4:0]  flags;
    int          lo;
    int          hi;
    flags = '0;
    if ($urandom_range(0, 99) < 8) flags = flags | FL_PLAY;
    if ($urandom_range(0, 99) < 8) flags = flags | FL_MIC;
    if ($urandom_range(0, 99) < 90) flags = flags | FL_MUSIC;
    if ($urandom_range(0, 99) < 75) flags = flags | FL_START;
    if ($urandom_range(0, 1) == 1) flags = flags | FL_PROC;
    case ($urandom_range(0, 9))
      0: bpm = '0;
      1: bpm = 16'($urandom);
      default: bpm = 16'($urandom_range(60, 200));
    endcase
    if ($urandom_range(0, 4) == 0) begin
      conf = 8'($urandom);
    end else begin
      lo = cur_conf - 3;
      hi = cur_conf + 3;
      if (lo < 0) lo = 0;
      if (hi > 255) hi = 255;
      conf = 8'($urandom_range(lo, hi));
    end
    case ($urandom_range(0, 9))
      0: onset = '0;
      1: onset = $urandom;
      2: onset = now_cursor + $urandom_range(1, 50);
      default: onset = now_cursor - $urandom_range(0, 2 * cur_onset + 2);
    endcase
    return compose_event(kind, now_cursor, bpm, conf, onset, flags);
  endfunction

  task automatic send_event(input lts_in_t e);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] toggle_ms, stable_ms, fallback_ms, onset_ms,
                               conf, fail_cd, ok_cd, record_ms);
    int widest;
    cfg_access(1'b1, REG_TOGGLE_DISPLAY, toggle_ms);
    cfg_access(1'b1, REG_MUSIC_STABLE, stable_ms);
    cfg_access(1'b1, REG_FALLBACK, fallback_ms);
    cfg_access(1'b1, REG_RECENT_ONSET, onset_ms);
    cfg_access(1'b1, REG_MIN_BEAT_CONF, conf);
    cfg_access(1'b1, REG_FAIL_COOLDOWN, fail_cd);
    cfg_access(1'b1, REG_OK_COOLDOWN, ok_cd);
    cfg_access(1'b1, REG_RECORD_DUR, record_ms);
    for (int i = 0; i < 8; i++) cfg_access(1'b0, 3'(i), '0);
    cur_fail_cd = fail_cd;
    cur_ok_cd = ok_cd;
    cur_onset = int'(onset_ms);
    cur_conf = int'(conf);
    widest = int'(toggle_ms);
    if (int'(stable_ms) > widest) widest = int'(stable_ms);
    if (int'(fallback_ms) > widest) widest = int'(fallback_ms);
    time_span = widest / 3 + 20;
    settings_used++;
  endtask

  // force the mode off, enable it, then run all event kinds on a moving clock
  task automatic play_session(input int len);
    int pick;
    if ($urandom_range(0, 3) == 0) now_cursor = $urandom;
    send_event(shaped_event(KIND_LINK_FAIL));
    send_event(shaped_event(KIND_TOGGLE));
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        now_cursor = now_cursor + (pick < 3 ? cur_fail_cd : cur_ok_cd) + $urandom_range(0, 40);
      else
        now_cursor = now_cursor + $urandom_range(0, time_span);
      pick = $urandom_range(0, 99);
      if (pick < 80) send_event(shaped_event(KIND_TICK));
      else if (pick < 92) send_event(shaped_event(KIND_PROCESSED));
      else if (pick < 96) send_event(shaped_event(KIND_TOGGLE));
      else if (pick < 98) send_event(shaped_event(KIND_LINK_FAIL));
      else send_event(compose_event(2'($urandom), $urandom, 16'($urandom), 8'($urandom),
                                    $urandom, 5'($urandom)));
    end
  endtask

  task automatic run_until(input int target);
    while (items_sent < target) play_session($urandom_range(8, 40));
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    steady = 1'b0;
    items_sent = 0;
    settings_used = 1;
    now_cursor = 32'd0;
    cur_fail_cd = RST_FAIL_COOLDOWN;
    cur_ok_cd = RST_OK_COOLDOWN;
    cur_onset = int'(RST_RECENT_ONSET);
    cur_conf = int'(RST_MIN_BEAT_CONF);
    time_span = int'(RST_MUSIC_STABLE) / 3 + 20;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_event(compose_event(KIND_TICK, 32'd100, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 5'b11111));
    send_event(compose_event(KIND_LINK_FAIL, 32'd200, 16'd0, 8'd0, 32'd0, 5'b00000));
    send_event(compose_event(KIND_PROCESSED, 32'd300, 16'd0, 8'd0, 32'd0, FL_PROC));
    send_event(compose_event(KIND_TOGGLE, 32'd1000, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd1500, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd1800, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd2000, 16'd0, 8'd0, 32'd0, FL_GO | FL_PLAY));
    send_event(compose_event(KIND_TICK, 32'd2100, 16'd0, 8'd0, 32'd0, FL_GO | FL_MIC));
    send_event(compose_event(KIND_TICK, 32'd2500, 16'd0, 8'd0, 32'd0, FL_START));
    send_event(compose_event(KIND_TICK, 32'd2600, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd4100, 16'd120, 8'd17, 32'd4090, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd4200, 16'd120, 8'd18, 32'd4019, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd4250, 16'd0, 8'd255, 32'd4250, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd4300, 16'd120, 8'd18, 32'd4120, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd4400, 16'd120, 8'd18, 32'd4400, FL_GO));
    send_event(compose_event(KIND_PROCESSED, 32'd5000, 16'd0, 8'd0, 32'd0, FL_PROC));
    send_event(compose_event(KIND_TICK, 32'd6000, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd425000, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd426600, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'd427800, 16'd0, 8'd0, 32'd0, FL_MUSIC));
    send_event(compose_event(KIND_LINK_FAIL, 32'd427900, 16'd0, 8'd0, 32'd0, 5'b00000));
    send_event(compose_event(KIND_TOGGLE, 32'hFFFF_FCF4, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'hFFFF_FD00, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_TICK, 32'h0000_0500, 16'd120, 8'd200, 32'h0000_0600, FL_GO));
    send_event(compose_event(KIND_TICK, 32'h0000_0510, 16'd120, 8'd200, 32'h0000_0508, FL_GO));
    send_event(compose_event(KIND_TOGGLE, 32'h0000_0600, 16'd0, 8'd0, 32'd0, FL_GO));
    send_event(compose_event(KIND_PROCESSED, 32'h0000_0700, 16'd0, 8'd0, 32'd0, 5'b00000));

    steady = 1'b1;
    run_until(250);
    steady = 1'b0;
    run_until(330);

    drain();
    apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_until(480);

    drain();
    apply_setting(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF);
    run_until(630);

    repeat (3) begin
      drain();
      apply_setting($urandom_range(0, 60), $urandom_range(0, 100), $urandom_range(0, 150),
                    $urandom_range(0, 80),
                    $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255),
                    $urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 65535));
      run_until(items_sent + 200);
    end

    drain();
    apply_setting($urandom_range(0, 2000), $urandom_range(0, 3000), $urandom_range(0, 3000),
                  $urandom_range(0, 300), $urandom_range(0, 60), $urandom_range(0, 100000),
                  $urandom_range(0, 100000), $urandom_range(0, 65535));
    run_until(1430);
    drain();

    $display("Sent %0d events under %0d register settings with idling on both channels",
             items_sent, settings_used);
    $display("Checked %0d results, %0d of them recording starts", checked, recordings_started);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
